// ===== hdl/cpr_pkg.sv =====
// shared types and constants for the capacity path reservation block
package cpr_pkg;
  localparam int unsigned NodeNum = 16;
  localparam int unsigned NodeW = 4;
  localparam int unsigned DistW = 5;

  typedef enum logic [1:0] {
    OP_SET_CAP  = 2'd0,
    OP_SET_LINK = 2'd1,
    OP_ROUTE    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINK2,
    ST_CLEAR,
    ST_PICK,
    ST_RELAX,
    ST_RELAX_W,
    ST_WALK,
    ST_EMIT,
    ST_TAKE_C,
    ST_TAKE_L1,
    ST_TAKE_L2,
    ST_OUT,
    ST_REJECT
  } state_e;

  typedef struct packed {
    logic [15:0] tag;
    logic        accepted;
    logic [3:0]  hop_node;
    logic        last;
    logic [15:0] admitted_total;
  } result_t;
endpackage

// ===== hdl/capacity_path_reservation.sv =====
// top level of the capacity path reservation block
// One request is worked on at a time; the next item may be taken while the
// last result still waits at the output. A set capacity item is done in the
// idle state; a set link item also passes through ST_LINK2 for the reverse
// direction. A route request runs a sequencer over one shared link memory read
// port and one compare unit. After reset the link memory is swept to zero (no
// items taken meanwhile). A search runs up to N rounds for N nodes in use, each
// picking the next node (ST_PICK) and relaxing its neighbours (ST_RELAX,
// ST_RELAX_W). A rejected request traces its path node by node, or goes at
// once to ST_REJECT for a bad endpoint, before its one result. An accepted
// path is traced back, committed in ST_EMIT and reserved hop by hop (ST_TAKE_C,
// ST_TAKE_L1, ST_TAKE_L2), then delivers one result per path node.
module capacity_path_reservation
  import cpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // op, node_a, node_b, amount, request_id, pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // tag, accepted, hop_node, admitted_total, pad
  output logic        m_axis_tlast_o
);
  state_e state_q, state_d;
  logic [4:0] ncnt_q;
  logic [7:0] cap_q [NodeNum];
  logic [15:0] adm_q;
  logic [DistW-1:0] dist_q [NodeNum];
  logic [NodeW-1:0] pred_q [NodeNum];
  logic [NodeNum-1:0] sett_q, reach_q;
  logic [NodeW-1:0] a_q, b_q, u_q, x_q;
  logic [7:0] amt_q;
  logic [15:0] rid_q;
  logic [4:0] lim;
  logic [4:0] i_q;
  logic [7:0] clr_q;
  logic clr_run_q;
  logic found_q;
  logic [NodeW-1:0] path_q [NodeNum];
  logic [4:0] n_q, k_q;
  result_t res_q;
  logic out_v_q;

  logic       we;
  logic [7:0] waddr, wdata, raddr, rdata;

  cpr_link_ram u_ram (
    .clk_i, .rst_ni, .clr_i(clr_run_q), .we_i(we), .waddr_i(waddr),
    .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign lim = (ncnt_q > 5'd16) ? 5'd16 : ncnt_q;
  assign cfg_ready_o = (state_q == ST_IDLE) && !clr_run_q;
  assign s_axis_tready_o = (state_q == ST_IDLE) && !clr_run_q;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o = {3'b000, res_q.admitted_total, res_q.hop_node,
                           res_q.accepted, res_q.tag};
  assign m_axis_tlast_o = res_q.last;

  logic [NodeW-1:0] iv;
  logic [NodeW-1:0] c_node, p_node;
  logic hop_ok, cand;
  logic [7:0] cu, cv;
  assign iv = i_q[NodeW-1:0];
  assign cu = cap_q[u_q];
  assign cv = cap_q[iv];
  assign hop_ok = (u_q == a_q && cu > 8'd0 && cv > 8'd1) ||
                  (iv == b_q && cu > 8'd1 && cv > 8'd0) ||
                  (cu > 8'd1 && cv > 8'd1);
  assign cand = !sett_q[iv] && reach_q[iv] && (!found_q || dist_q[iv] < dist_q[u_q]);
  assign c_node = path_q[k_q[NodeW-1:0]];
  assign p_node = path_q[k_q[NodeW-1:0] + 4'd1];

  always_comb begin
    we = 1'b0;
    waddr = {a_q, b_q};
    wdata = amt_q;
    raddr = {u_q, iv};
    if (clr_run_q) begin
      we = 1'b1; waddr = clr_q; wdata = 8'd0;
    end else if (state_q == ST_IDLE && s_axis_tvalid_i && s_axis_tready_o
                 && s_axis_tdata_i[1:0] == OP_SET_LINK) begin
      we = 1'b1; waddr = {s_axis_tdata_i[5:2], s_axis_tdata_i[9:6]};
      wdata = s_axis_tdata_i[17:10];
    end else if (state_q == ST_LINK2) begin
      we = 1'b1; waddr = {b_q, a_q};
    end else if (state_q == ST_RELAX_W) begin
      raddr = {u_q, iv + 4'd1};
    end else if (state_q == ST_TAKE_C) begin
      raddr = {c_node, p_node};
    end else if (state_q == ST_TAKE_L1) begin
      raddr = {p_node, c_node};
      we = (rdata != 8'd0); waddr = {c_node, p_node}; wdata = rdata - 8'd1;
    end else if (state_q == ST_TAKE_L2) begin
      we = (rdata != 8'd0); waddr = {p_node, c_node}; wdata = rdata - 8'd1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid_i && s_axis_tready_o) begin
        unique case (op_e'(s_axis_tdata_i[1:0]))
          OP_SET_LINK: state_d = ST_LINK2;
          OP_ROUTE:    state_d = ST_CLEAR;
          default:     state_d = ST_IDLE;
        endcase
      end
      ST_LINK2: state_d = ST_IDLE;
      ST_CLEAR: state_d = ({1'b0, a_q} >= lim || {1'b0, b_q} >= lim) ? ST_REJECT : ST_PICK;
      ST_PICK: if (i_q + 5'd1 >= lim) begin
        state_d = (found_q || cand) ? ST_RELAX : ST_WALK;
      end
      ST_RELAX: state_d = ST_RELAX_W;
      ST_RELAX_W: if (i_q + 5'd1 >= lim) state_d = (n_q + 5'd1 >= lim) ? ST_WALK : ST_PICK;
      ST_WALK: begin
        if (!reach_q[x_q] || cap_q[x_q] < (((x_q == a_q) || (x_q == b_q)) ? 8'd1 : 8'd2)
            || k_q == 5'd16) state_d = ST_REJECT;
        else if (x_q == a_q) state_d = ST_EMIT;
      end
      ST_EMIT: state_d = (k_q == 5'd1) ? ST_OUT : ST_TAKE_C;
      ST_TAKE_C: state_d = ST_TAKE_L1;
      ST_TAKE_L1: state_d = ST_TAKE_L2;
      ST_TAKE_L2: state_d = (k_q + 5'd2 >= n_q) ? ST_OUT : ST_TAKE_C;
      ST_OUT: if (!out_v_q || m_axis_tready_i) begin
        if (k_q + 5'd1 >= n_q) state_d = ST_IDLE;
      end
      ST_REJECT: if (!out_v_q || m_axis_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ncnt_q <= 5'd16;
      adm_q <= '0;
      clr_q <= '0;
      clr_run_q <= 1'b1;
      out_v_q <= 1'b0;
      for (int j = 0; j < NodeNum; j++) cap_q[j] <= '0;
    end else begin
      state_q <= state_d;
      if (clr_run_q) begin
        clr_q <= clr_q + 8'd1;
        if (clr_q == 8'd255) clr_run_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) ncnt_q <= cfg_data_i;
      if (out_v_q && m_axis_tready_i && state_q != ST_OUT && state_q != ST_REJECT)
        out_v_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid_i && s_axis_tready_o
                     && s_axis_tdata_i[1:0] == OP_SET_CAP)
          cap_q[s_axis_tdata_i[5:2]] <= s_axis_tdata_i[17:10];
        ST_TAKE_C: begin
          if (cap_q[c_node] != 8'd0) cap_q[c_node] <= cap_q[c_node] - 8'd1;
        end
        ST_TAKE_L1: begin
          if (cap_q[p_node] != 8'd0) cap_q[p_node] <= cap_q[p_node] - 8'd1;
        end
        ST_EMIT: adm_q <= adm_q + 16'd1;
        ST_OUT: if (!out_v_q || m_axis_tready_i) out_v_q <= 1'b1;
        ST_REJECT: if (!out_v_q || m_axis_tready_i) out_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid_i && s_axis_tready_o) begin
        a_q <= s_axis_tdata_i[5:2];
        b_q <= s_axis_tdata_i[9:6];
        amt_q <= s_axis_tdata_i[17:10];
        rid_q <= s_axis_tdata_i[33:18];
      end
      ST_CLEAR: begin
        sett_q <= '0;
        for (int j = 0; j < NodeNum; j++) begin
          dist_q[j] <= '0;
          reach_q[j] <= (NodeW'(j) == a_q);
          pred_q[j] <= (NodeW'(j) == a_q) ? a_q : '0;
        end
        i_q <= '0; n_q <= '0; found_q <= 1'b0; u_q <= '0;
      end
      ST_PICK: begin
        if (cand) begin
          u_q <= iv; found_q <= 1'b1;
        end
        if (i_q + 5'd1 >= lim) begin
          i_q <= '0;
          if (found_q || cand) sett_q[cand ? iv : u_q] <= 1'b1;
          x_q <= b_q; k_q <= '0;
        end else i_q <= i_q + 5'd1;
      end
      ST_RELAX: ;
      ST_RELAX_W: begin
        if (!sett_q[iv] && !(reach_q[iv] && dist_q[u_q] + 5'd1 >= dist_q[iv])
            && rdata != 8'd0 && hop_ok) begin
          dist_q[iv] <= dist_q[u_q] + 5'd1;
          pred_q[iv] <= u_q;
          reach_q[iv] <= 1'b1;
        end
        if (i_q + 5'd1 >= lim) begin
          i_q <= '0; n_q <= n_q + 5'd1; found_q <= 1'b0;
          x_q <= b_q; k_q <= '0;
        end else i_q <= i_q + 5'd1;
      end
      ST_WALK: begin
        path_q[k_q[NodeW-1:0]] <= x_q;
        k_q <= k_q + 5'd1;
        x_q <= pred_q[x_q];
      end
      ST_EMIT: begin
        n_q <= k_q;
        k_q <= '0;
      end
      ST_TAKE_L2: begin
        if (k_q + 5'd2 >= n_q) k_q <= '0;
        else k_q <= k_q + 5'd1;
      end
      ST_OUT: if (!out_v_q || m_axis_tready_i) begin
        res_q.tag <= rid_q;
        res_q.accepted <= 1'b1;
        res_q.hop_node <= path_q[4'(n_q - 5'd1 - k_q)];
        res_q.last <= (k_q + 5'd1 >= n_q);
        res_q.admitted_total <= adm_q;
        k_q <= k_q + 5'd1;
      end
      ST_REJECT: if (!out_v_q || m_axis_tready_i) begin
        res_q.tag <= rid_q;
        res_q.accepted <= 1'b0;
        res_q.hop_node <= '0;
        res_q.last <= 1'b1;
        res_q.admitted_total <= adm_q;
      end
      default: ;
    endcase
  end

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready_o) else $error("ready while busy");
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res_q.accepted) |-> res_q.last) else $error("reject not last");
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_run_q |-> !s_axis_tready_o) else $error("item taken during clear");
endmodule

// ===== hdl/cpr_link_ram.sv =====
// link channel matrix memory, one write and one registered read port
module cpr_link_ram
  import cpr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clr_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] raddr_i,
  output logic [7:0] rdata_o
);
  logic [7:0] mem_q [256];
  logic [7:0] rd_q;
  logic       clr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= 1'b1;
    else clr_q <= clr_i;
  end

  assign rdata_o = clr_q ? 8'd0 : rd_q;
endmodule
